// ----- sv/crba_pkg.sv -----
// Package for the contiguous run block allocator: field widths, reset
// constants and the command/status structs shared by controller and datapath.
// No dependencies.
package crba_pkg;

  localparam int NUM_BLOCKS_DEF = 4096;
  localparam int LEN_W          = 13;
  localparam int BLK_W          = 12;
  localparam int CNT_W          = 13;
  localparam int IN_DATA_W      = 32;
  localparam int OUT_DATA_W     = 40;
  localparam logic [LEN_W-1:0] BLOCK_COUNT_RST = 13'd4096;
  localparam logic [CNT_W-1:0] COUNT_MAX       = 13'd8191;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;       // write one entry of the power-up fill
    logic load;      // capture an accepted request
    logic scan_rd;   // read the bitmap at the scan index
    logic scan_ev;   // evaluate the bit just read
    logic finalize;  // close the trailing run
    logic mark;      // clear one bit of the chosen run
    logic commit;    // latch the allocate result and lower the count
    logic free_rd;   // read the bitmap at the block to free
    logic free_ev;   // set the bit if it was used
    logic emit;      // load the output register
  } crba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic want_zero;
    logic blk_bad;
    logic scan_empty;
    logic hit;
    logic last;
    logic mark_done;
  } crba_sts_t;

endpackage

// ----- sv/crba_dp.sv -----
// Datapath of the run allocator: free bitmap memory, scan counters, best-run
// registers, free count, configuration register and output register.
// Depends on crba_pkg.
module crba_dp
  import crba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  crba_cmd_t             cmd,
  output crba_sts_t             sts,
  input  logic                  func,
  input  logic [LEN_W-1:0]      request_length,
  input  logic [BLK_W-1:0]      block_number,
  input  logic                  cfg_we,
  input  logic [LEN_W-1:0]      cfg_data,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam int FT_RST = ((NUM_BLOCKS < 4096) ? NUM_BLOCKS : 4096) - 1;

  logic          mem [NUM_BLOCKS];
  logic          rd_bit;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic          wr_bit;

  logic [LEN_W-1:0] block_count;
  logic [CNT_W-1:0] free_total;
  logic [AW-1:0]    clr_idx;

  logic             req_free;
  logic [LEN_W-1:0] want;
  logic [BLK_W-1:0] blk;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    cur_s;
  logic [CW-1:0]    cur_l;
  logic [AW-1:0]    best_s;
  logic [CW-1:0]    best_l;
  logic [CW-1:0]    mark_k;
  logic [BLK_W-1:0] res_start;
  logic [LEN_W-1:0] res_len;

  logic [CW-1:0] n_act;
  logic [CW-1:0] bc_ext;
  logic [CW-1:0] blk_ext;
  logic [CW-1:0] cur_inc;
  logic [CW-1:0] ft_ext;
  logic [CW-1:0] start_ext;

  assign bc_ext    = CW'(block_count);
  assign n_act     = (bc_ext < CW'(NUM_BLOCKS)) ? bc_ext : CW'(NUM_BLOCKS);
  assign blk_ext   = CW'(blk);
  assign cur_inc   = cur_l + CW'(1);
  assign ft_ext    = CW'(free_total);
  assign start_ext = CW'(best_s);

  always_comb begin
    sts.clr_done   = (clr_idx == AW'(NUM_BLOCKS - 1));
    sts.is_free    = req_free;
    sts.want_zero  = (want == '0);
    sts.blk_bad    = (blk == '0) || (blk_ext >= n_act);
    sts.scan_empty = (n_act < CW'(2));
    sts.hit        = rd_bit && (cur_inc == CW'(want));
    sts.last       = ((CW'(idx) + CW'(1)) >= n_act);
    sts.mark_done  = (mark_k == best_l);
  end

  always_comb begin
    rd_addr = cmd.free_rd ? blk_ext[AW-1:0] : idx;
    wr_en   = 1'b0;
    wr_addr = clr_idx;
    wr_bit  = 1'b0;
    if (cmd.clr) begin
      wr_en  = 1'b1;
      wr_bit = (clr_idx != '0);
    end else if (cmd.mark && !sts.mark_done) begin
      wr_en   = 1'b1;
      wr_addr = best_s + mark_k[AW-1:0];
    end else if (cmd.free_ev && !rd_bit) begin
      wr_en   = 1'b1;
      wr_addr = blk_ext[AW-1:0];
      wr_bit  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (cmd.scan_rd || cmd.free_rd) begin
      rd_bit <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RST;
      free_total  <= CNT_W'(FT_RST);
      clr_idx     <= '0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_data;
      end
      if (cmd.clr && !sts.clr_done) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (cmd.commit) begin
        free_total <= (best_l > ft_ext) ? '0 : CNT_W'(ft_ext - best_l);
      end else if (cmd.free_ev && !rd_bit && free_total != COUNT_MAX) begin
        free_total <= free_total + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_free  <= func;
      want      <= request_length;
      blk       <= block_number;
      idx       <= AW'(1);
      cur_s     <= '0;
      cur_l     <= '0;
      best_s    <= '0;
      best_l    <= '0;
      res_start <= '0;
      res_len   <= '0;
    end
    if (cmd.scan_ev) begin
      idx <= idx + AW'(1);
      if (rd_bit) begin
        if (cur_l == '0) begin
          cur_s <= idx;
        end
        cur_l <= cur_inc;
        if (sts.hit) begin
          best_s <= (cur_l == '0) ? idx : cur_s;
          best_l <= cur_inc;
        end
      end else begin
        if (cur_l > best_l) begin
          best_s <= cur_s;
          best_l <= cur_l;
        end
        cur_l <= '0;
      end
    end
    if (cmd.finalize) begin
      mark_k <= '0;
      if (cur_l > best_l) begin
        best_s <= cur_s;
        best_l <= cur_l;
      end
    end
    if (cmd.mark && !sts.mark_done) begin
      mark_k <= mark_k + CW'(1);
    end
    if (cmd.commit) begin
      res_start <= start_ext[BLK_W-1:0];
      res_len   <= best_l[LEN_W-1:0];
    end
    if (cmd.emit) begin
      out_data <= {2'b00, free_total, res_len, res_start};
    end
  end

endmodule

// ----- sv/crba_ctrl.sv -----
// Controller of the run allocator: sequences the power-up fill, the bitmap
// scan, the run marking and the free update, and owns both handshakes.
// Depends on crba_pkg.
module crba_ctrl
  import crba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  crba_sts_t sts,
  output crba_cmd_t cmd,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SEV   = 4'd4;
  localparam logic [3:0] S_FINAL = 4'd5;
  localparam logic [3:0] S_MARK  = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FEV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_free) begin
          state_next = sts.blk_bad ? S_DONE : S_FRD;
        end else if (sts.want_zero) begin
          state_next = S_DONE;
        end else if (sts.scan_empty) begin
          state_next = S_FINAL;
        end else begin
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SEV;
      end
      S_SEV: begin
        cmd.scan_ev = 1'b1;
        state_next  = (sts.hit || sts.last) ? S_FINAL : S_SRD;
      end
      S_FINAL: begin
        cmd.finalize = 1'b1;
        state_next   = S_MARK;
      end
      S_MARK: begin
        if (sts.mark_done) begin
          cmd.commit = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.mark = 1'b1;
        end
      end
      S_FRD: begin
        cmd.free_rd = 1'b1;
        state_next  = S_FEV;
      end
      S_FEV: begin
        cmd.free_ev = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DISP)
    else $error("accepted request did not move to dispatch");
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready)
    else $error("input taken during bitmap fill");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result emitted without output valid");
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> slot_free)
    else $error("result overwrote an untaken result");
`endif

endmodule

// ----- sv/contiguous_run_block_allocator_unit.sv -----
// Contiguous run block allocator. After reset the bitmap is filled one entry
// per cycle before the first request is taken. An allocate request passes
// through dispatch, a read and an evaluate state per block scanned, finalize,
// a mark state that clears the granted run's bits, and done. The scan runs
// from block 1 to where the first free run reaches the requested length, or
// over the whole volume, via the single-bit bitmap memory port. Freeing goes
// through dispatch, bitmap read, bitmap evaluate and done; a zero-length
// request or ignored free goes from dispatch to done. One request is in work
// at a time; the output register lets the next one enter while a result waits.
module contiguous_run_block_allocator_unit
  import crba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // request_length[12:0], block_number[24:13]
  input  logic                  s_axis_tuser,   // func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // run_start[11:0], run_length[24:12],
                                                // free_blocks[37:25]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LEN_W-1:0]      cfg_data        // block_count
);

  crba_cmd_t cmd;
  crba_sts_t sts;

  assign cfg_ready = 1'b1;

  crba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .cmd       (cmd),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

  crba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .func           (s_axis_tuser),
    .request_length (s_axis_tdata[12:0]),
    .block_number   (s_axis_tdata[24:13]),
    .cfg_we         (cfg_valid),
    .cfg_data       (cfg_data),
    .out_data       (m_axis_tdata)
  );

endmodule
